// File: rtl/udr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udr_pkg
// Shared types and constants for the websocket unmask / upcase / reframe block.
// ----------------------------------------------------------------------------
package udr_pkg;

    localparam logic [7:0] HDR_TEXT_FIN  = 8'h81;
    localparam logic [6:0] LEN_CODE_MAX7 = 7'd125;
    localparam logic [6:0] LEN_CODE_16   = 7'd126;
    localparam logic [7:0] LEN_BYTE_16   = 8'd126;
    localparam int unsigned KEY_BYTES    = 4;

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_DATA = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    // one queued request from the parser to the emitter
    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;
        logic [15:0] value;
    } cmd_t;

endpackage : udr_pkg
`default_nettype wire

// File: rtl/udr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udr_front
// Frame parser: tracks the client header, captures the key, unmasks and
// upcases payload bytes and issues one request per producing input byte.
// ----------------------------------------------------------------------------
module udr_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    output logic                in_stall,
    input  wire logic           queue_full,
    output logic                push,
    output udr_pkg::cmd_t       push_cmd
);

    udr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] done_reg, done_next;
    logic [31:0] key_reg, key_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [7:0]  key_byte;
    logic [7:0]  plain;
    logic [7:0]  upper;
    logic        data_last;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        case (done_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain = in_byte ^ key_byte;
    assign upper = (plain >= 8'h61 && plain <= 8'h7A) ? (plain - 8'h20) : plain;
    assign data_last = ({1'b0, done_reg} + 17'd1) >= {1'b0, len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        done_next   = done_reg;
        key_next    = key_reg;
        len_hi_next = len_hi_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_cmd    = '{kind: udr_pkg::CMD_ERR, last: 1'b0, value: 16'd0};

        if (accept)
        begin
            if (halted_reg)
            begin
                push = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    udr_pkg::PH_HDR1:
                    begin
                        if (in_byte[6:0] <= udr_pkg::LEN_CODE_MAX7)
                        begin
                            len_next   = {9'd0, in_byte[6:0]};
                            done_next  = 16'd0;
                            phase_next = udr_pkg::PH_KEY;
                        end
                        else if (in_byte[6:0] == udr_pkg::LEN_CODE_16)
                        begin
                            phase_next = udr_pkg::PH_LENHI;
                        end
                        else
                        begin
                            halted_next = 1'b1;
                            push        = 1'b1;
                        end
                    end
                    udr_pkg::PH_LENHI:
                    begin
                        len_hi_next = in_byte;
                        phase_next  = udr_pkg::PH_LENLO;
                    end
                    udr_pkg::PH_LENLO:
                    begin
                        len_next   = {len_hi_reg, in_byte};
                        done_next  = 16'd0;
                        phase_next = udr_pkg::PH_KEY;
                    end
                    udr_pkg::PH_KEY:
                    begin
                        key_next  = {key_reg[23:0], in_byte};
                        done_next = done_reg + 16'd1;
                        if (done_reg >= 16'(udr_pkg::KEY_BYTES - 1))
                        begin
                            push          = 1'b1;
                            push_cmd.kind = udr_pkg::CMD_HDR;
                            push_cmd.value = len_reg;
                            done_next     = 16'd0;
                            phase_next    = (len_reg == 16'd0) ? udr_pkg::PH_HDR0
                                                               : udr_pkg::PH_DATA;
                        end
                    end
                    udr_pkg::PH_DATA:
                    begin
                        push           = 1'b1;
                        push_cmd.kind  = udr_pkg::CMD_DATA;
                        push_cmd.last  = data_last;
                        push_cmd.value = {8'd0, upper};
                        done_next      = done_reg + 16'd1;
                        if (data_last)
                        begin
                            done_next  = 16'd0;
                            phase_next = udr_pkg::PH_HDR0;
                        end
                    end
                    default:
                    begin
                        phase_next = udr_pkg::PH_HDR1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= udr_pkg::PH_HDR0;
            len_reg    <= 16'd0;
            done_reg   <= 16'd0;
            key_reg    <= 32'd0;
            len_hi_reg <= 8'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            done_reg   <= done_next;
            key_reg    <= key_next;
            len_hi_reg <= len_hi_next;
            halted_reg <= halted_next;
        end
    end

endmodule : udr_front
`default_nettype wire

// File: rtl/udr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udr_queue
// Small request queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module udr_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  udr_pkg::cmd_t       push_cmd,
    output logic                full,
    input  wire logic           pop,
    output udr_pkg::cmd_t       head,
    output logic                empty
);

    udr_pkg::cmd_t mem [udr_pkg::QUEUE_DEPTH];

    logic [udr_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [udr_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [udr_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full    = count_reg == (udr_pkg::QUEUE_AW+1)'(udr_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : udr_queue
`default_nettype wire

// File: rtl/udr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udr_back
// Frame emitter: expands queued requests into server frame bytes and holds
// them in an output register.
// ----------------------------------------------------------------------------
module udr_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  udr_pkg::cmd_t       head,
    input  wire logic           empty,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                length_error
);

    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    logic       load;
    logic       short_len;

    assign load      = !valid_reg || !out_stall;
    assign short_len = head.value < 16'(udr_pkg::LEN_BYTE_16);

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        pop        = 1'b0;

        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                last_next = 1'b0;
                err_next  = 1'b0;
                pop       = 1'b1;
                step_next = 2'd0;
                case (head.kind)
                    udr_pkg::CMD_HDR:
                    begin
                        // short form: 0x81 len; long form: 0x81 126 hi lo
                        case (step_reg)
                            2'd0:
                            begin
                                byte_next = udr_pkg::HDR_TEXT_FIN;
                                pop       = 1'b0;
                                step_next = 2'd1;
                            end
                            2'd1:
                            begin
                                if (short_len)
                                begin
                                    byte_next = head.value[7:0];
                                    last_next = head.value == 16'd0;
                                end
                                else
                                begin
                                    byte_next = udr_pkg::LEN_BYTE_16;
                                    pop       = 1'b0;
                                    step_next = 2'd2;
                                end
                            end
                            2'd2:
                            begin
                                byte_next = head.value[15:8];
                                pop       = 1'b0;
                                step_next = 2'd3;
                            end
                            default:
                            begin
                                byte_next = head.value[7:0];
                            end
                        endcase
                    end
                    udr_pkg::CMD_DATA:
                    begin
                        byte_next = head.value[7:0];
                        last_next = head.last;
                    end
                    default:
                    begin
                        byte_next = 8'd0;
                        err_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign length_error = err_reg;

endmodule : udr_back
`default_nettype wire

// File: rtl/websocket_unmask_upcase_reframe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_unmask_upcase_reframe
// Client frame deframer, unmasker and upcaser that re-emits server text frames.
// ----------------------------------------------------------------------------
// path: the first result of an input byte is written into the request queue and
//   then loaded into the output register
// throughput: one input byte per cycle unless in_stall is high; payload bytes
//   leave one per cycle unless out_stall is high; a frame header is two or four
//   bytes, absorbed by an eight-entry request queue between parser and emitter
// reset: asynchronous, active low; parser returns to the first header byte,
//   queue and output register empty, error halt cleared
module websocket_unmask_upcase_reframe
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     in_byte,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                length_error
);

    logic          push;
    udr_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          pop;
    udr_pkg::cmd_t head;
    logic          empty;

    udr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .in_stall   (in_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    udr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    udr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .length_error (length_error)
    );

endmodule : websocket_unmask_upcase_reframe
`default_nettype wire

// File: rtl/udr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udr_checker
// Port-level checks for the websocket unmask / upcase / reframe block.
// ----------------------------------------------------------------------------
module udr_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       out_last,
    input  wire logic       length_error
);

    logic err_seen_reg;

    // sticky once an error request has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && length_error)
        begin
            err_seen_reg <= 1'b1;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("stalled input request changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(out_last) && $stable(length_error))
        else $error("stalled output changed");

    a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> out_byte == 8'd0 && !out_last)
        else $error("error result carries data");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err_seen_reg |-> length_error)
        else $error("normal result after halt");

    a_no_last_in_halt: assert property (@(posedge clk) disable iff (!rst_n)
        err_seen_reg |-> !(out_valid && out_last))
        else $error("frame end after halt");

endmodule : udr_checker

bind websocket_unmask_upcase_reframe udr_checker u_udr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .length_error (length_error)
);
`default_nettype wire
